// File: rtl/beam_packet_loss_monitor_top_macros.svh
// Assertion macros used by the monitor's top-level RTL.
`ifndef BEAM_PACKET_LOSS_MONITOR_TOP_MACROS_SVH
`define BEAM_PACKET_LOSS_MONITOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bplm_pkg.sv
package bplm_pkg;

  localparam int NUM_BEAMS  = 4;
  localparam int BEAM_W     = 2;
  localparam int LEN_W      = 16;
  localparam int WORD_W     = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CLASS_LONG    = 2'd0;
  localparam logic [1:0] CLASS_SHORT   = 2'd1;
  localparam logic [1:0] CLASS_INVALID = 2'd2;

  localparam logic [1:0] SEQ_IN_ORDER    = 2'd0;
  localparam logic [1:0] SEQ_GAP         = 2'd1;
  localparam logic [1:0] SEQ_COUNT_ERR   = 2'd2;
  localparam logic [1:0] SEQ_NOT_CHECKED = 2'd3;

  localparam logic [1:0] REG_LONG_MIN      = 2'd0;
  localparam logic [1:0] REG_SHORT_FLOOR   = 2'd1;
  localparam logic [1:0] REG_SHORT_CEILING = 2'd2;

  localparam logic [LEN_W-1:0] LONG_MIN_RESET      = 16'd1440;
  localparam logic [LEN_W-1:0] SHORT_FLOOR_RESET   = 16'd10;
  localparam logic [LEN_W-1:0] SHORT_CEILING_RESET = 16'd1400;

  localparam logic [WORD_W-1:0] BEAM_KEYS [NUM_BEAMS] = '{
    32'h1111_1111, 32'h3333_3333, 32'h7777_7777, 32'h5555_5555
  };

  typedef struct packed {
    logic [LEN_W-1:0] long_min;
    logic [LEN_W-1:0] short_floor;
    logic [LEN_W-1:0] short_ceiling;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        cls;
    logic [BEAM_W-1:0] beam;
    logic              kvalid;
    logic [WORD_W-1:0] seq;
  } stage_t;

  typedef struct packed {
    logic [1:0]        packet_class;
    logic [BEAM_W-1:0] beam_index;
    logic              key_valid;
    logic [1:0]        seq_status;
    logic [WORD_W-1:0] seq_gap;
    logic              pair_loss;
    logic [WORD_W-1:0] total_dropped;
    logic [WORD_W-1:0] total_long;
    logic [WORD_W-1:0] total_short;
    logic [WORD_W-1:0] beam_total;
  } result_t;

endpackage

// File: rtl/bplm_ifs.sv
interface bplm_item_if;
  logic        valid;
  logic        ready;
  logic [15:0] packet_length;
  logic [31:0] beam_key;
  logic [31:0] sequence_number;

  modport source (output valid, packet_length, beam_key, sequence_number, input ready);
  modport sink (input valid, packet_length, beam_key, sequence_number, output ready);
endinterface

interface bplm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  packet_class;
  logic [1:0]  beam_index;
  logic        key_valid;
  logic [1:0]  seq_status;
  logic [31:0] seq_gap;
  logic        pair_loss;
  logic [31:0] total_dropped;
  logic [31:0] total_long;
  logic [31:0] total_short;
  logic [31:0] beam_total;

  modport source (
    output valid, packet_class, beam_index, key_valid, seq_status, seq_gap, pair_loss,
           total_dropped, total_long, total_short, beam_total,
    input  ready
  );
  modport sink (
    input  valid, packet_class, beam_index, key_valid, seq_status, seq_gap, pair_loss,
           total_dropped, total_long, total_short, beam_total,
    output ready
  );
endinterface

// File: rtl/beam_packet_loss_monitor_top.sv
// Datagram loss monitor. Each item transaction carries one datagram summary
// (length, beam key, sequence number) and produces exactly one result
// transaction with the datagram's class, decoded beam, sequence check and the
// running counters after that datagram. The block takes one item per clock
// cycle unless a waiting result stalls it. An item passes the input register
// that holds the length class and decoded beam, then the counter update
// that loads the result register. The per-beam sequence and count registers
// are read and written in that same update, so consecutive items on one
// beam need no stall. The length thresholds sit in the APB registers at byte
// addresses 0, 4 and 8 and should only be written while the block is idle.
`include "beam_packet_loss_monitor_top_macros.svh"

module beam_packet_loss_monitor_top (
  input  logic                             clk,
  input  logic                             rst,
  bplm_item_if.sink                        item,
  bplm_result_if.source                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bplm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bplm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bplm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import bplm_pkg::*;

  cfg_t    cfg;
  stage_t  stage;
  result_t res;
  logic    take;

  bplm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bplm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .take            (take),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .packet_length   (item.packet_length),
    .beam_key        (item.beam_key),
    .sequence_number (item.sequence_number),
    .stage           (stage)
  );

  bplm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .take      (take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .res       (res)
  );

  assign result.packet_class  = res.packet_class;
  assign result.beam_index    = res.beam_index;
  assign result.key_valid     = res.key_valid;
  assign result.seq_status    = res.seq_status;
  assign result.seq_gap       = res.seq_gap;
  assign result.pair_loss     = res.pair_loss;
  assign result.total_dropped = res.total_dropped;
  assign result.total_long    = res.total_long;
  assign result.total_short   = res.total_short;
  assign result.beam_total    = res.beam_total;

  `BPLM_ASSERT_NEXT(a_accept_loads_stage, clk, rst, item.valid && item.ready, stage.valid, "accepted item did not reach the input register")
  `BPLM_ASSERT_NOW(a_key_only_long, clk, rst, result.valid && result.key_valid, result.packet_class == CLASS_LONG, "key reported valid on a datagram that is not long")
  `BPLM_ASSERT_NOW(a_invalid_quiet, clk, rst, result.valid && result.packet_class == CLASS_INVALID, !result.pair_loss && result.seq_status == SEQ_NOT_CHECKED && result.seq_gap == '0, "invalid datagram reported a loss or a sequence check")
  `BPLM_ASSERT_NOW(a_gap_only_on_gap, clk, rst, result.valid && result.seq_status != SEQ_GAP, result.seq_gap == '0, "sequence gap reported without gap status")

endmodule

// File: rtl/bplm_cfg.sv
module bplm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bplm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bplm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bplm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output bplm_pkg::cfg_t                    cfg
);
  import bplm_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_min      <= LONG_MIN_RESET;
      cfg.short_floor   <= SHORT_FLOOR_RESET;
      cfg.short_ceiling <= SHORT_CEILING_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LONG_MIN:      cfg.long_min      <= pwdata[LEN_W-1:0];
        REG_SHORT_FLOOR:   cfg.short_floor   <= pwdata[LEN_W-1:0];
        REG_SHORT_CEILING: cfg.short_ceiling <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_LONG_MIN:      prdata = CFG_DATA_W'(cfg.long_min);
      REG_SHORT_FLOOR:   prdata = CFG_DATA_W'(cfg.short_floor);
      REG_SHORT_CEILING: prdata = CFG_DATA_W'(cfg.short_ceiling);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/bplm_front.sv
module bplm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  bplm_pkg::cfg_t                cfg,
  input  logic                          take,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bplm_pkg::LEN_W-1:0]    packet_length,
  input  logic [bplm_pkg::WORD_W-1:0]   beam_key,
  input  logic [bplm_pkg::WORD_W-1:0]   sequence_number,
  output bplm_pkg::stage_t              stage
);
  import bplm_pkg::*;

  logic [1:0]        cls_next;
  logic [BEAM_W-1:0] beam_next;
  logic              kvalid_next;
  logic              accept;

  assign in_ready = !stage.valid || take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    beam_next   = '0;
    kvalid_next = 1'b0;
    if (packet_length >= cfg.long_min) begin
      cls_next = CLASS_LONG;
      for (int i = NUM_BEAMS - 1; i >= 0; i--) begin
        if (beam_key == BEAM_KEYS[i]) begin
          beam_next   = BEAM_W'(i);
          kvalid_next = 1'b1;
        end
      end
    end else if (packet_length > cfg.short_floor && packet_length < cfg.short_ceiling) begin
      cls_next = CLASS_SHORT;
    end else begin
      cls_next = CLASS_INVALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      if (accept) begin
        stage.valid  <= 1'b1;
        stage.cls    <= cls_next;
        stage.beam   <= beam_next;
        stage.kvalid <= kvalid_next;
        stage.seq    <= sequence_number;
      end else if (take) begin
        stage.valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/bplm_core.sv
module bplm_core (
  input  logic               clk,
  input  logic               rst,
  input  bplm_pkg::stage_t   stage,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output bplm_pkg::result_t  res
);
  import bplm_pkg::*;

  logic [WORD_W-1:0] last_seq   [NUM_BEAMS];
  logic [WORD_W-1:0] beam_cnt   [NUM_BEAMS];
  logic [WORD_W-1:0] long_cnt;
  logic [WORD_W-1:0] short_cnt;
  logic [WORD_W-1:0] drop_cnt;

  logic [WORD_W-1:0] long_cnt_next;
  logic [WORD_W-1:0] short_cnt_next;
  logic [WORD_W-1:0] drop_cnt_next;
  logic [WORD_W-1:0] beam_cnt_next;
  logic [WORD_W-1:0] expected;
  logic [WORD_W-1:0] long_inc;
  logic [WORD_W-1:0] short_inc;
  logic [WORD_W-1:0] excess;
  logic [WORD_W-1:0] gap;
  logic [1:0]        status;
  logic              ploss;
  result_t           res_next;

  assign take      = stage.valid && (!out_valid || out_ready);
  assign expected  = last_seq[stage.beam] + WORD_W'(1);
  assign long_inc  = long_cnt + WORD_W'(1);
  assign short_inc = short_cnt + WORD_W'(1);

  always_comb begin
    long_cnt_next  = long_cnt;
    short_cnt_next = short_cnt;
    beam_cnt_next  = beam_cnt[stage.beam];
    excess         = '0;
    gap            = '0;
    status         = SEQ_NOT_CHECKED;
    ploss          = 1'b0;
    case (stage.cls)
      CLASS_LONG: begin
        long_cnt_next = long_inc;
        if (stage.kvalid) begin
          beam_cnt_next = beam_cnt[stage.beam] + WORD_W'(1);
        end
        if (long_inc > short_inc) begin
          excess         = long_inc - short_inc;
          short_cnt_next = long_cnt;
          ploss          = 1'b1;
        end
        if (expected == stage.seq) begin
          status = SEQ_IN_ORDER;
        end else if (expected < stage.seq) begin
          status = SEQ_GAP;
          gap    = stage.seq - expected;
        end else begin
          status = SEQ_COUNT_ERR;
        end
      end
      CLASS_SHORT: begin
        short_cnt_next = short_inc;
        if (long_cnt < short_inc) begin
          excess        = short_inc - long_cnt;
          long_cnt_next = short_inc;
          ploss         = 1'b1;
        end
      end
      default: ;
    endcase
    drop_cnt_next = drop_cnt + excess + gap;

    res_next.packet_class  = stage.cls;
    res_next.beam_index    = stage.beam;
    res_next.key_valid     = stage.kvalid;
    res_next.seq_status    = status;
    res_next.seq_gap       = gap;
    res_next.pair_loss     = ploss;
    res_next.total_dropped = drop_cnt_next;
    res_next.total_long    = long_cnt_next;
    res_next.total_short   = short_cnt_next;
    res_next.beam_total    = beam_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BEAMS; i++) begin
        last_seq[i] <= '0;
        beam_cnt[i] <= '0;
      end
      long_cnt  <= '0;
      short_cnt <= '0;
      drop_cnt  <= '0;
    end else if (take) begin
      long_cnt             <= long_cnt_next;
      short_cnt            <= short_cnt_next;
      drop_cnt             <= drop_cnt_next;
      beam_cnt[stage.beam] <= beam_cnt_next;
      if (stage.cls == CLASS_LONG) begin
        last_seq[stage.beam] <= stage.seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

// File: tb/sv/bplm_result_checker.sv
module bplm_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  bplm_item_if                            item,
  bplm_result_if                          result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bplm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bplm_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int unsigned                     fail_count,
  output int unsigned                     reports_in_flight
);
  import bplm_pkg::*;

  cfg_t        thresholds;
  logic [31:0] last_seq [NUM_BEAMS];
  logic [31:0] beam_count [NUM_BEAMS];
  logic [31:0] long_count;
  logic [31:0] short_count;
  logic [31:0] drop_count;
  result_t     datagram_reports [$];

  initial begin
    fail_count = 0;
    reports_in_flight = 0;
  end

  function automatic result_t classify_datagram(input logic [15:0] len, input logic [31:0] key,
                                                input logic [31:0] seq);
    result_t     r;
    logic [31:0] next_seq;
    logic [31:0] excess;
    logic [1:0]  b;
    logic        hit;
    r = '0;
    r.packet_class = CLASS_INVALID;
    r.seq_status = SEQ_NOT_CHECKED;
    b = 2'd0;
    hit = 1'b0;
    if (len >= thresholds.long_min) begin
      r.packet_class = CLASS_LONG;
      long_count = long_count + 32'd1;
      case (key)
        BEAM_KEYS[0]: begin b = 2'd0; hit = 1'b1; end
        BEAM_KEYS[1]: begin b = 2'd1; hit = 1'b1; end
        BEAM_KEYS[2]: begin b = 2'd2; hit = 1'b1; end
        BEAM_KEYS[3]: begin b = 2'd3; hit = 1'b1; end
        default: begin b = 2'd0; hit = 1'b0; end
      endcase
      if (hit) begin
        beam_count[b] = beam_count[b] + 32'd1;
      end
      next_seq = last_seq[b] + 32'd1;
      if (long_count > short_count + 32'd1) begin
        excess = long_count - short_count - 32'd1;
        short_count = short_count + excess;
        drop_count = drop_count + excess;
        r.pair_loss = 1'b1;
      end
      if (next_seq == seq) begin
        r.seq_status = SEQ_IN_ORDER;
      end else if (next_seq < seq) begin
        r.seq_status = SEQ_GAP;
        r.seq_gap = seq - next_seq;
        drop_count = drop_count + r.seq_gap;
      end else begin
        r.seq_status = SEQ_COUNT_ERR;
      end
      last_seq[b] = seq;
    end else if (len > thresholds.short_floor && len < thresholds.short_ceiling) begin
      r.packet_class = CLASS_SHORT;
      short_count = short_count + 32'd1;
      if (long_count < short_count) begin
        excess = short_count - long_count;
        drop_count = drop_count + excess;
        long_count = long_count + excess;
        r.pair_loss = 1'b1;
      end
    end
    r.beam_index = b;
    r.key_valid = hit;
    r.total_dropped = drop_count;
    r.total_long = long_count;
    r.total_short = short_count;
    r.beam_total = beam_count[b];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, actual %0h", name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : observe
    result_t want;
    if (rst) begin
      thresholds.long_min = 16'd1440;
      thresholds.short_floor = 16'd10;
      thresholds.short_ceiling = 16'd1400;
      for (int i = 0; i < NUM_BEAMS; i++) begin
        last_seq[i] = '0;
        beam_count[i] = '0;
      end
      long_count = '0;
      short_count = '0;
      drop_count = '0;
      datagram_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_LONG_MIN: thresholds.long_min = pwdata[15:0];
          REG_SHORT_FLOOR: thresholds.short_floor = pwdata[15:0];
          REG_SHORT_CEILING: thresholds.short_ceiling = pwdata[15:0];
          default: ;
        endcase
      end
      if (item.valid && item.ready) begin
        datagram_reports.push_back(classify_datagram(item.packet_length, item.beam_key,
                                                     item.sequence_number));
      end
      if (result.valid && result.ready) begin
        if (datagram_reports.size() == 0) begin
          $error("result transaction arrived with no datagram outstanding");
          fail_count++;
        end else begin
          want = datagram_reports.pop_front();
          check_field("packet_class", 32'(want.packet_class), 32'(result.packet_class));
          check_field("beam_index", 32'(want.beam_index), 32'(result.beam_index));
          check_field("key_valid", 32'(want.key_valid), 32'(result.key_valid));
          check_field("seq_status", 32'(want.seq_status), 32'(result.seq_status));
          check_field("seq_gap", want.seq_gap, result.seq_gap);
          check_field("pair_loss", 32'(want.pair_loss), 32'(result.pair_loss));
          check_field("total_dropped", want.total_dropped, result.total_dropped);
          check_field("total_long", want.total_long, result.total_long);
          check_field("total_short", want.total_short, result.total_short);
          check_field("beam_total", want.beam_total, result.beam_total);
        end
      end
    end
    reports_in_flight = datagram_reports.size();
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import bplm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           fail_count;
  int unsigned           reports_in_flight;
  int unsigned           cycle_count = 0;
  logic [15:0]           long_min;
  logic [15:0]           short_floor;
  logic [15:0]           short_ceiling;
  logic [31:0]           next_seq [NUM_BEAMS];
  int                    burst_left;
  logic                  long_turn;

  bplm_item_if   item_ch ();
  bplm_result_if result_ch ();

  beam_packet_loss_monitor_top dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bplm_result_checker result_checker (
    .clk               (clk),
    .rst               (rst),
    .item              (item_ch),
    .result            (result_ch),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .reports_in_flight (reports_in_flight)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("beam_packet_loss_monitor_top: mismatch");
      $finish;
    end
  end

  initial begin : result_stalls
    int unsigned stall_mode;
    int unsigned stall_left;
    stall_mode = 0;
    stall_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 120);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: result_ch.ready = 1'b1;
        1: result_ch.ready = 1'($urandom_range(0, 1));
        2: result_ch.ready = ($urandom_range(0, 3) == 0);
        default: result_ch.ready = ((cycle_count % 7) >= 2);
      endcase
    end
  end

  task automatic send_datagram(input logic [15:0] len, input logic [31:0] key,
                               input logic [31:0] seq);
    int unsigned gap;
    item_ch.valid = 1'b1;
    item_ch.packet_length = len;
    item_ch.beam_key = key;
    item_ch.sequence_number = seq;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_ch.valid = 1'b0;
        item_ch.packet_length = 16'($urandom);
        item_ch.beam_key = $urandom;
        item_ch.sequence_number = $urandom;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic apb_write(input logic [1:0] reg_index, input logic [15:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {reg_index, 2'b00};
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input logic [15:0] lmin, input logic [15:0] floor_len,
                           input logic [15:0] ceil_len);
    item_ch.valid = 1'b0;
    while (reports_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_write(REG_LONG_MIN, lmin);
    apb_write(REG_SHORT_FLOOR, floor_len);
    apb_write(REG_SHORT_CEILING, ceil_len);
    long_min = lmin;
    short_floor = floor_len;
    short_ceiling = ceil_len;
  endtask

  task automatic random_datagram();
    logic [15:0] len;
    logic [31:0] key;
    logic [31:0] seq;
    int          b;
    int          l;
    int          pick;
    b = $urandom_range(0, NUM_BEAMS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      if (long_turn) begin
        key = BEAM_KEYS[b];
        l = int'(long_min) + int'($urandom_range(0, 400));
        if (l > 65535) begin
          l = 65535;
        end
        len = l[15:0];
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          seq = next_seq[b] + $urandom_range(1, 50);
        end else if (pick == 1) begin
          seq = next_seq[b] - $urandom_range(1, 5);
        end else begin
          seq = next_seq[b];
        end
        next_seq[b] = seq + 32'd1;
      end else begin
        if (int'(short_ceiling) > int'(short_floor) + 1) begin
          len = 16'($urandom_range(int'(short_floor) + 1, int'(short_ceiling) - 1));
        end else begin
          len = 16'($urandom);
        end
        key = $urandom;
        seq = $urandom;
      end
      if ($urandom_range(0, 9) != 0) begin
        long_turn = ~long_turn;
      end
    end else begin
      case ($urandom_range(0, 9))
        0: len = 16'h0000;
        1: len = 16'hFFFF;
        2: len = long_min;
        3: len = long_min - 16'd1;
        4: len = short_floor;
        5: len = short_floor + 16'd1;
        6: len = short_ceiling;
        7: len = short_ceiling - 16'd1;
        default: len = 16'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0: key = $urandom;
        1: key = BEAM_KEYS[b] ^ (32'd1 << $urandom_range(0, 31));
        default: key = BEAM_KEYS[b];
      endcase
      seq = $urandom;
    end
    send_datagram(len, key, seq);
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.packet_length = '0;
    item_ch.beam_key = '0;
    item_ch.sequence_number = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    long_min = 16'd1440;
    short_floor = 16'd10;
    short_ceiling = 16'd1400;
    burst_left = 0;
    long_turn = 1'b1;
    for (int i = 0; i < NUM_BEAMS; i++) begin
      next_seq[i] = 32'd1;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_datagram(16'd0, 32'h0, 32'h0);
    send_datagram(16'd11, BEAM_KEYS[0], 32'd5);
    send_datagram(16'd1440, BEAM_KEYS[0], 32'd1);
    send_datagram(16'd65535, BEAM_KEYS[1], 32'd1);
    send_datagram(16'd1399, BEAM_KEYS[2], 32'd7);
    send_datagram(16'd1400, BEAM_KEYS[2], 32'd8);
    send_datagram(16'd1439, BEAM_KEYS[2], 32'd9);
    send_datagram(16'd10, BEAM_KEYS[3], 32'd10);
    send_datagram(16'd1440, BEAM_KEYS[2], 32'hFFFF_FFFF);
    send_datagram(16'd1440, BEAM_KEYS[2], 32'h0);
    send_datagram(16'd1440, BEAM_KEYS[3], 32'd100);
    send_datagram(16'd1440, BEAM_KEYS[3], 32'd50);
    send_datagram(16'd1440, BEAM_KEYS[3], 32'd50);
    send_datagram(16'd1440, 32'h1234_5678, 32'd2);
    send_datagram(16'd1441, 32'h1111_1110, 32'd3);
    send_datagram(16'd1500, BEAM_KEYS[0], 32'd4);
    send_datagram(16'd2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_datagram(16'd12, 32'h0, 32'hFFFF_FFFF);
    send_datagram(16'd13, 32'hFFFF_FFFF, 32'h0);
    send_datagram(16'd700, BEAM_KEYS[1], 32'd2);
    send_datagram(16'd700, BEAM_KEYS[1], 32'd3);
    send_datagram(16'd700, BEAM_KEYS[1], 32'd4);
    send_datagram(16'd1440, BEAM_KEYS[1], 32'd2);
    send_datagram(16'd1440, BEAM_KEYS[0], 32'h8000_0000);

    configure(16'd1440, 16'd10, 16'd1400);
    repeat (150) random_datagram();
    configure(16'd0, 16'd0, 16'd65535);
    repeat (130) random_datagram();
    configure(16'd65535, 16'd0, 16'd65535);
    repeat (130) random_datagram();
    configure(16'd65535, 16'd65535, 16'd0);
    repeat (130) random_datagram();
    repeat (2) begin
      configure(16'($urandom_range(100, 4000)), 16'($urandom_range(0, 200)),
                16'($urandom_range(300, 3000)));
      repeat (135) random_datagram();
    end
    configure(16'($urandom), 16'($urandom), 16'($urandom));
    repeat (135) random_datagram();

    item_ch.valid = 1'b0;
    while (reports_in_flight != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && reports_in_flight == 0) begin
      $display("beam_packet_loss_monitor_top: match");
    end else begin
      $display("beam_packet_loss_monitor_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/bplm_pkg.sv
rtl/bplm_ifs.sv
rtl/bplm_cfg.sv
rtl/bplm_front.sv
rtl/bplm_core.sv
rtl/beam_packet_loss_monitor_top.sv
tb/sv/bplm_result_checker.sv
tb/sv/testbench.sv
